// File: sv/tmtp_pkg.sv
// Shared types, codes and constants for the tempo-map transport position block.
package tmtp_pkg;

  localparam int MAX_MARKERS = 16;
  localparam int MK_IW       = $clog2(MAX_MARKERS);
  localparam int MK_CW       = MK_IW + 1;

  localparam int BEAT_W = 32;
  localparam int BPM_W  = 20;
  localparam int ACC_W  = 51;   // seconds accumulator, Q16.16; 17 full segments at 1/256 bpm
  localparam int DEN_W  = 33;   // divisor: tempo, the 15360 seconds-per-minute constant or loop length
  localparam int MULA_W = 58;   // multiplicand and product
  localparam int SUM_W  = 59;

  localparam logic [ACC_W-1:0]  SEC_PER_MIN_Q8 = ACC_W'(15360);
  localparam logic [DEN_W-1:0]  MIN_LOOP_LEN   = DEN_W'(2048);
  localparam logic [BPM_W-1:0]  BPM_RESET      = BPM_W'(30720);

  typedef enum logic [2:0] {
    OP_ADVANCE  = 3'd0,
    OP_PLAY     = 3'd1,
    OP_STOP     = 3'd2,
    OP_RECORD   = 3'd3,
    OP_REWIND   = 3'd4,
    OP_SET_POS  = 3'd5,
    OP_WR_MARK  = 3'd6,
    OP_NONE     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_STOPPED   = 2'd0,
    MODE_PLAYING   = 2'd1,
    MODE_RECORDING = 2'd2
  } mode_t;

  localparam logic [2:0] CFG_LOOP_EN  = 3'd0;
  localparam logic [2:0] CFG_LOOP_ST  = 3'd1;
  localparam logic [2:0] CFG_LOOP_END = 3'd2;
  localparam logic [2:0] CFG_DEF_BPM  = 3'd3;
  localparam logic [2:0] CFG_MK_COUNT = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEG_WAIT,
    ST_SEG_DONE,
    ST_SAT_DIV,
    ST_SAT_MUL1,
    ST_SAT_MUL2,
    ST_SAT_DIV2,
    ST_WRAP_DIV,
    ST_DONE
  } state_t;

  function automatic logic [BPM_W-1:0] fix_bpm(input logic [BPM_W-1:0] b);
    fix_bpm = (b == '0) ? BPM_W'(1) : b;
  endfunction

endpackage

// File: sv/tmtp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tmtp_div import tmtp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [ACC_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(ACC_W);

  logic [ACC_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             ge;

  assign shifted = {rem_r, num_r[ACC_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign ge      = ~diff[DEN_W+1];

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      num_nxt = {num_r[ACC_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

// File: sv/tempo_map_transport_position.sv
// Tempo-map transport position: top level with marker table and sequencer.
//
// Keeps a Q16.16 beat position and a stopped/playing/recording mode, plus a
// table of up to 16 tempo markers. Every input beat gives exactly one output
// beat carrying the position and mode after it. Mode changes, rewind, set
// position and marker writes go from idle straight to the done state. An
// advance while running walks the markers twice (beat to seconds, then seconds
// back to beats; from position zero only the way back); each non-empty segment
// costs one pass of the shared 51-step serial divider, and the final conversion
// adds two 20-step serial multiplies, two divides and, on a loop wrap, one more
// divide. A new input beat is taken while a finished result still waits in the
// output register.
// Marker slots must be written before marker_count covers them.
module tempo_map_transport_position import tmtp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // delta_seconds[31:0], beat_value[63:32],
                                  // bpm_value[83:64], marker_index[87:84]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // position_beat[31:0], transport_mode[33:32],
                                  // zero pad [39:34]
);

  // config registers
  logic              loop_en_r;
  logic [BEAT_W-1:0] loop_st_r, loop_end_r;
  logic [BPM_W-1:0]  def_bpm_r;
  logic [4:0]        mk_count_r;

  // marker table
  logic [BEAT_W-1:0] mk_beat_r [MAX_MARKERS];
  logic [BPM_W-1:0]  mk_bpm_r  [MAX_MARKERS];

  // transport state and sequencer
  state_t            state_r, state_nxt;
  logic [BEAT_W-1:0] pos_r, pos_nxt;
  mode_t             mode_r, mode_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BEAT_W-1:0] out_pos_r, out_pos_nxt;
  mode_t             out_mode_r, out_mode_nxt;

  logic              phase_b_r, phase_b_nxt;   // 0: beats to seconds, 1: back
  logic              tail_r, tail_nxt;
  logic [MK_CW-1:0]  idx_r, idx_nxt;
  logic [BEAT_W-1:0] prev_r, prev_nxt;
  logic [BEAT_W-1:0] tgt_r, tgt_nxt;
  logic [BPM_W-1:0]  bpm_r, bpm_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  seg_r, seg_nxt;
  logic [BEAT_W-1:0] delta_r, delta_nxt;
  logic [13:0]       frac_r, frac_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  // serial multiplier
  logic [MULA_W-1:0] mul_a_r, mul_a_nxt;
  logic [BPM_W-1:0]  mul_b_r, mul_b_nxt;
  logic [MULA_W-1:0] mul_p_r, mul_p_nxt;
  logic [4:0]        mul_cnt_r, mul_cnt_nxt;
  logic [MULA_W-1:0] mul_step;
  logic              mul_last;

  // divider
  logic              div_start;
  logic [ACC_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [ACC_W-1:0]  div_quot;
  logic [DEN_W-1:0]  div_rem;

  // input fields
  op_t               in_op;
  logic [BEAT_W-1:0] in_delta, in_beat;
  logic [BPM_W-1:0]  in_bpm;
  logic [MK_IW-1:0]  in_idx;
  logic              in_acc;
  logic              mk_wr;

  // effective loop
  logic [BEAT_W-1:0] eff_st, loop_hi;
  logic [DEN_W-1:0]  loop_lo, eff_end, loop_len;

  // scan helpers
  logic [MK_CW-1:0]  n_used;
  logic [BEAT_W-1:0] cur_mb;
  logic [BPM_W-1:0]  cur_bpm;
  logic [BEAT_W-1:0] seg_tgt, seg_diff;
  logic [ACC_W-1:0]  seg_dacc;
  logic [SUM_W-1:0]  sat_sum;
  logic [BEAT_W-1:0] sat_pos;

  assign in_op    = op_t'(in_tuser);
  assign in_delta = in_tdata[31:0];
  assign in_beat  = in_tdata[63:32];
  assign in_bpm   = in_tdata[83:64];
  assign in_idx   = in_tdata[87:84];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign mk_wr     = in_acc && (in_op == OP_WR_MARK);

  assign eff_st   = (loop_st_r < loop_end_r) ? loop_st_r : loop_end_r;
  assign loop_hi  = (loop_st_r > loop_end_r) ? loop_st_r : loop_end_r;
  assign loop_lo  = {1'b0, eff_st} + MIN_LOOP_LEN;
  assign eff_end  = (loop_lo > {1'b0, loop_hi}) ? loop_lo : {1'b0, loop_hi};
  assign loop_len = eff_end - {1'b0, eff_st};

  assign n_used  = (mk_count_r > 5'(MAX_MARKERS)) ? MK_CW'(MAX_MARKERS) : MK_CW'(mk_count_r);
  assign cur_mb  = mk_beat_r[idx_r[MK_IW-1:0]];
  assign cur_bpm = fix_bpm(mk_bpm_r[idx_r[MK_IW-1:0]]);

  // segment end in the scan state: the marker, or the position itself
  assign seg_tgt  = (!phase_b_r && (idx_r >= n_used || cur_mb >= pos_r)) ? pos_r : cur_mb;
  assign seg_diff = seg_tgt - prev_r;
  assign seg_dacc = ACC_W'(seg_diff);

  assign mul_step = mul_p_r + (mul_b_r[0] ? mul_a_r : '0);
  assign mul_last = (mul_cnt_r == 5'(BPM_W - 1));

  assign sat_sum = sum_r + SUM_W'(div_quot);
  assign sat_pos = (sat_sum[SUM_W-1:BEAT_W] != '0) ? '1 : sat_sum[BEAT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_mode_nxt  = out_mode_r;
    phase_b_nxt   = phase_b_r;
    tail_nxt      = tail_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    tgt_nxt       = tgt_r;
    bpm_nxt       = bpm_r;
    acc_nxt       = acc_r;
    seg_nxt       = seg_r;
    delta_nxt     = delta_r;
    frac_nxt      = frac_r;
    sum_nxt       = sum_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_p_nxt     = mul_p_r;
    mul_cnt_nxt   = mul_cnt_r;
    div_start     = 1'b0;
    div_num       = acc_r;
    div_den       = {13'b0, bpm_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DONE;
          unique case (in_op)
            OP_ADVANCE: begin
              if (mode_r != MODE_STOPPED && in_delta != '0) begin
                delta_nxt   = in_delta;
                idx_nxt     = '0;
                prev_nxt    = '0;
                bpm_nxt     = fix_bpm(def_bpm_r);
                state_nxt   = ST_SCAN;
                // position zero is zero seconds: go straight to the way back
                phase_b_nxt = (pos_r == '0);
                acc_nxt     = (pos_r == '0) ? ACC_W'(in_delta) : '0;
              end
            end
            OP_PLAY:    mode_nxt = MODE_PLAYING;
            OP_STOP:    mode_nxt = MODE_STOPPED;
            OP_RECORD:  mode_nxt = MODE_RECORDING;
            OP_REWIND:  pos_nxt  = loop_en_r ? eff_st : '0;
            OP_SET_POS: pos_nxt  = in_beat;
            OP_WR_MARK: ;
            default:    ;
          endcase
        end
      end

      ST_SCAN: begin
        if (idx_r < n_used && cur_mb == '0) begin
          // marker at beat zero only sets the tempo
          bpm_nxt = cur_bpm;
          idx_nxt = idx_r + MK_CW'(1);
        end else if (phase_b_r && idx_r >= n_used) begin
          div_start = 1'b1;
          div_num   = acc_r;
          div_den   = SEC_PER_MIN_Q8[DEN_W-1:0];
          state_nxt = ST_SAT_DIV;
        end else begin
          tgt_nxt  = seg_tgt;
          tail_nxt = !phase_b_r && (idx_r >= n_used || cur_mb >= pos_r);
          if (seg_tgt <= prev_r) begin
            seg_nxt   = '0;
            state_nxt = ST_SEG_DONE;
          end else begin
            div_start = 1'b1;
            div_num   = (seg_dacc << 14) - (seg_dacc << 10);   // times 15360
            div_den   = {13'b0, bpm_r};
            state_nxt = ST_SEG_WAIT;
          end
        end
      end

      ST_SEG_WAIT: begin
        if (div_done) begin
          seg_nxt   = div_quot;
          state_nxt = ST_SEG_DONE;
        end
      end

      ST_SEG_DONE: begin
        if (!phase_b_r) begin
          if (tail_r) begin
            acc_nxt     = acc_r + seg_r + ACC_W'(delta_r);
            phase_b_nxt = 1'b1;
            idx_nxt     = '0;
            prev_nxt    = '0;
            bpm_nxt     = fix_bpm(def_bpm_r);
          end else begin
            acc_nxt  = acc_r + seg_r;
            prev_nxt = tgt_r;
            bpm_nxt  = cur_bpm;
            idx_nxt  = idx_r + MK_CW'(1);
          end
          state_nxt = ST_SCAN;
        end else if (acc_r < seg_r) begin
          div_start = 1'b1;
          div_num   = acc_r;
          div_den   = SEC_PER_MIN_Q8[DEN_W-1:0];
          state_nxt = ST_SAT_DIV;
        end else begin
          acc_nxt   = acc_r - seg_r;
          prev_nxt  = tgt_r;
          bpm_nxt   = cur_bpm;
          idx_nxt   = idx_r + MK_CW'(1);
          state_nxt = ST_SCAN;
        end
      end

      // rem seconds split into whole minutes-of-256 and a fraction
      ST_SAT_DIV: begin
        if (div_done) begin
          frac_nxt    = div_rem[13:0];
          mul_a_nxt   = MULA_W'(div_quot);
          mul_b_nxt   = bpm_r;
          mul_p_nxt   = '0;
          mul_cnt_nxt = '0;
          state_nxt   = ST_SAT_MUL1;
        end
      end

      ST_SAT_MUL1: begin
        mul_p_nxt   = mul_step;
        mul_a_nxt   = mul_a_r << 1;
        mul_b_nxt   = mul_b_r >> 1;
        mul_cnt_nxt = mul_cnt_r + 5'd1;
        if (mul_last) begin
          sum_nxt     = SUM_W'(prev_r) + SUM_W'(mul_step);
          mul_a_nxt   = MULA_W'(frac_r);
          mul_b_nxt   = bpm_r;
          mul_p_nxt   = '0;
          mul_cnt_nxt = '0;
          state_nxt   = ST_SAT_MUL2;
        end
      end

      ST_SAT_MUL2: begin
        mul_p_nxt   = mul_step;
        mul_a_nxt   = mul_a_r << 1;
        mul_b_nxt   = mul_b_r >> 1;
        mul_cnt_nxt = mul_cnt_r + 5'd1;
        if (mul_last) begin
          div_start = 1'b1;
          div_num   = mul_step[ACC_W-1:0];
          div_den   = SEC_PER_MIN_Q8[DEN_W-1:0];
          state_nxt = ST_SAT_DIV2;
        end
      end

      ST_SAT_DIV2: begin
        if (div_done) begin
          pos_nxt = sat_pos;
          if (loop_en_r && {1'b0, sat_pos} >= eff_end) begin
            div_start = 1'b1;
            div_num   = ACC_W'(sat_pos - eff_end[BEAT_W-1:0]);
            div_den   = loop_len;
            state_nxt = ST_WRAP_DIV;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_WRAP_DIV: begin
        if (div_done) begin
          pos_nxt   = eff_st + div_rem[BEAT_W-1:0];
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_mode_nxt  = mode_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  tmtp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      mode_r      <= MODE_STOPPED;
      out_valid_r <= 1'b0;
      loop_en_r   <= 1'b0;
      loop_st_r   <= '0;
      loop_end_r  <= '0;
      def_bpm_r   <= BPM_RESET;
      mk_count_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_LOOP_EN:  loop_en_r  <= cfg_data[0];
          CFG_LOOP_ST:  loop_st_r  <= cfg_data;
          CFG_LOOP_END: loop_end_r <= cfg_data;
          CFG_DEF_BPM:  def_bpm_r  <= cfg_data[BPM_W-1:0];
          CFG_MK_COUNT: mk_count_r <= cfg_data[4:0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r  <= out_pos_nxt;
    out_mode_r <= out_mode_nxt;
    phase_b_r  <= phase_b_nxt;
    tail_r     <= tail_nxt;
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    tgt_r      <= tgt_nxt;
    bpm_r      <= bpm_nxt;
    acc_r      <= acc_nxt;
    seg_r      <= seg_nxt;
    delta_r    <= delta_nxt;
    frac_r     <= frac_nxt;
    sum_r      <= sum_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    mul_p_r    <= mul_p_nxt;
    mul_cnt_r  <= mul_cnt_nxt;
    if (mk_wr) begin
      mk_beat_r[in_idx] <= in_beat;
      mk_bpm_r[in_idx]  <= in_bpm;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_mode_r, out_pos_r};

endmodule
